// File: src/wms_pkg.sv
// Shared types, codes and helpers for the waypoint mission sequencer.
`default_nettype none

package wms_pkg;

  // Route and field sizes.
  localparam int unsigned MaxPoints  = 16;
  localparam int unsigned CountW     = 5;
  localparam int unsigned IndexW     = 4;
  localparam int unsigned RetryW     = 4;
  localparam int unsigned CounterW   = 32;
  localparam int unsigned LimitsW    = 64;
  localparam int unsigned OpW        = 4;
  localparam int unsigned CmdW       = 3;
  localparam int unsigned ModeW      = 3;
  localparam int unsigned AddrW      = 5;
  localparam int unsigned DataW      = 64;

  // Register indexes (byte address is eight times the index).
  localparam logic [1:0] RegWaypointCount   = 2'd0;
  localparam logic [1:0] RegRetryLimits     = 2'd1;
  localparam logic [1:0] RegLoopForever     = 2'd2;
  localparam logic [1:0] RegContinueOnError = 2'd3;

  // Event codes.
  localparam logic [OpW-1:0] OpValidate  = 4'd0;
  localparam logic [OpW-1:0] OpActivate  = 4'd1;
  localparam logic [OpW-1:0] OpReady     = 4'd2;
  localparam logic [OpW-1:0] OpSuccess   = 4'd3;
  localparam logic [OpW-1:0] OpError     = 4'd4;
  localparam logic [OpW-1:0] OpRetryTmr  = 4'd5;
  localparam logic [OpW-1:0] OpStop      = 4'd6;
  localparam logic [OpW-1:0] OpStopDone  = 4'd7;
  localparam logic [OpW-1:0] OpAbort     = 4'd8;

  // Command codes.
  localparam logic [CmdW-1:0] CmdNone     = 3'd0;
  localparam logic [CmdW-1:0] CmdDispatch = 3'd1;
  localparam logic [CmdW-1:0] CmdWait     = 3'd2;
  localparam logic [CmdW-1:0] CmdRetry    = 3'd3;
  localparam logic [CmdW-1:0] CmdCancel   = 3'd4;
  localparam logic [CmdW-1:0] CmdStopped  = 3'd5;
  localparam logic [CmdW-1:0] CmdComplete = 3'd6;
  localparam logic [CmdW-1:0] CmdFail     = 3'd7;

  // Mission mode codes.
  localparam logic [ModeW-1:0] ModeIdle       = 3'd0;
  localparam logic [ModeW-1:0] ModeValidating = 3'd1;
  localparam logic [ModeW-1:0] ModeWaiting    = 3'd2;
  localparam logic [ModeW-1:0] ModeNavigating = 3'd3;
  localparam logic [ModeW-1:0] ModeRetryWait  = 3'd4;
  localparam logic [ModeW-1:0] ModeStopping   = 3'd5;
  localparam logic [ModeW-1:0] ModeCompleted  = 3'd6;
  localparam logic [ModeW-1:0] ModeFailed     = 3'd7;

  // Configuration seen by the decision logic.
  typedef struct packed {
    logic [CountW-1:0]  waypoint_count;
    logic [LimitsW-1:0] retry_limits;
    logic               wrap_route;
    logic               skip_exhausted;
  } cfg_t;

  // Mission status held between events.
  typedef struct packed {
    logic [ModeW-1:0]    mode;
    logic                active;
    logic                loaded;
    logic [IndexW-1:0]   index;
    logic [RetryW-1:0]   retry;
    logic [CounterW-1:0] done;
    logic [CounterW-1:0] missed;
    logic [CounterW-1:0] laps;
  } status_t;

  // One decision: the command and the status after the event.
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    status_t         status;
  } step_t;

  // Saturating increment of a status counter.
  function automatic logic [CounterW-1:0] sat_inc(input logic [CounterW-1:0] v);
    sat_inc = (&v) ? v : v + CounterW'(1);
  endfunction

endpackage

`default_nettype wire

// File: src/waypoint_mission_sequencer.sv
// Top level of the waypoint mission sequencer: event register, status and result register.
//
//  Channel   Direction  Handshake               Payload
//  in        sink       in_valid_i/in_stall_o   operation_i, executor_ready_i
//  out       source     out_valid_o/out_stall_i command_o .. laps_o (8 fields)
//  cfg       APB slave  psel/penable/pready     paddr, pwdata, prdata
//
// An event is registered on acceptance and decided from the event register,
// and its result is loaded into the result register once that register is free.
// One event is taken every cycle unless a stalled result holds the flow; the
// throughput is set by the single decision stage between the event register
// and the result register. Reset clears status, configuration and both valid flags.
// A stalled result holds the result register; a full event register then holds
// and in_stall_o rises, so no event is dropped.
`default_nettype none

module waypoint_mission_sequencer import wms_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Event channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [OpW-1:0]      operation_i,
  input  wire logic                executor_ready_i,
  // Result channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [CmdW-1:0]          command_o,
  output logic [ModeW-1:0]         mode_o,
  output logic                     is_active_o,
  output logic [IndexW-1:0]        point_index_o,
  output logic [RetryW-1:0]        retry_number_o,
  output logic [CounterW-1:0]      done_points_o,
  output logic [CounterW-1:0]      missed_points_o,
  output logic [CounterW-1:0]      laps_o,
  // Configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrW-1:0]    paddr,
  input  wire logic [DataW-1:0]    pwdata,
  output logic      [DataW-1:0]    prdata,
  output logic                     pready
);

  cfg_t           cfg;
  status_t        status_q;
  step_t          step;
  logic           ev_valid_q;
  logic [OpW-1:0] op_q;
  logic           rdy_q;
  logic           out_blocked;
  logic           fire;
  logic           out_valid_q;
  step_t          res_q;

  wms_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wms_step u_step (
    .op_i         (op_q),
    .exec_ready_i (rdy_q),
    .cfg_i        (cfg),
    .status_i     (status_q),
    .step_o       (step)
  );

  // Handshake: the result register frees up when empty or being taken.
  assign out_blocked = out_valid_q && out_stall_i;
  assign fire        = ev_valid_q && !out_blocked;
  assign in_stall_o  = ev_valid_q && out_blocked;

  // Event register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      ev_valid_q <= in_valid_i;
    end
  end

  // Event register payload.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      op_q  <= operation_i;
      rdy_q <= executor_ready_i;
    end
  end

  // Mission status is updated as each event is decided.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
    end else if (fire) begin
      status_q <= step.status;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_blocked) begin
      out_valid_q <= ev_valid_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= step;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign command_o       = res_q.cmd;
  assign mode_o          = res_q.status.mode;
  assign is_active_o     = res_q.status.active;
  assign point_index_o   = res_q.status.index;
  assign retry_number_o  = res_q.status.retry;
  assign done_points_o   = res_q.status.done;
  assign missed_points_o = res_q.status.missed;
  assign laps_o          = res_q.status.laps;

endmodule

`default_nettype wire

// File: src/wms_cfg.sv
// Configuration register file with its APB-style access port.
`default_nettype none

module wms_cfg import wms_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [CountW-1:0]  count_q;
  logic [LimitsW-1:0] limits_q;
  logic               loop_q;
  logic               cont_q;
  logic               wr_en;
  logic [1:0]         reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[4:3];

  // Register writes complete in the access cycle of a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      limits_q <= '0;
      loop_q   <= 1'b0;
      cont_q   <= 1'b0;
    end else if (wr_en) begin
      case (reg_sel)
        RegWaypointCount:   count_q  <= pwdata[CountW-1:0];
        RegRetryLimits:     limits_q <= pwdata[LimitsW-1:0];
        RegLoopForever:     loop_q   <= pwdata[0];
        RegContinueOnError: cont_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (reg_sel)
      RegWaypointCount:   prdata = {{(DataW-CountW){1'b0}}, count_q};
      RegRetryLimits:     prdata = limits_q;
      RegLoopForever:     prdata = {{(DataW-1){1'b0}}, loop_q};
      RegContinueOnError: prdata = {{(DataW-1){1'b0}}, cont_q};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = '{waypoint_count: count_q,
                   retry_limits:   limits_q,
                   wrap_route:     loop_q,
                   skip_exhausted: cont_q};

endmodule

`default_nettype wire

// File: src/wms_step.sv
// Decision logic: one event applied to the current mission status.
`default_nettype none

module wms_step import wms_pkg::*; (
  input  wire logic [OpW-1:0] op_i,
  input  wire logic           exec_ready_i,
  input  wire cfg_t           cfg_i,
  input  wire status_t        status_i,
  output step_t               step_o
);

  logic [CountW-1:0] route_len;
  logic [CountW-1:0] next_pos;
  logic              more_points;
  logic              index_out;
  logic [RetryW-1:0] limit;

  // Route length is capped at the route capacity.
  assign route_len   = (cfg_i.waypoint_count > CountW'(MaxPoints))
                       ? CountW'(MaxPoints) : cfg_i.waypoint_count;
  assign next_pos    = {1'b0, status_i.index} + CountW'(1);
  assign more_points = next_pos < route_len;
  assign index_out   = {1'b0, status_i.index} >= route_len;
  assign limit       = cfg_i.retry_limits[status_i.index * RetryW +: RetryW];

  // Move past the current waypoint: next point, wrap with a lap, or complete.
  function automatic step_t advance(input status_t s, input logic more,
                                    input logic loop_en);
    step_t r;
    r.status = s;
    if (more) begin
      r.status.index = s.index + IndexW'(1);
      r.status.mode  = ModeNavigating;
      r.cmd          = CmdDispatch;
    end else if (loop_en) begin
      r.status.laps  = sat_inc(s.laps);
      r.status.index = '0;
      r.status.mode  = ModeNavigating;
      r.cmd          = CmdDispatch;
    end else begin
      r.status.mode   = ModeCompleted;
      r.status.active = 1'b0;
      r.cmd           = CmdComplete;
    end
    return r;
  endfunction

  always_comb begin
    status_t s;
    s      = status_i;
    step_o = '{cmd: CmdNone, status: status_i};
    case (op_i)
      OpValidate: begin
        step_o.status        = '0;
        step_o.status.mode   = ModeValidating;
        step_o.status.active = 1'b1;
      end
      OpActivate: begin
        step_o.status        = '0;
        step_o.status.loaded = 1'b1;
        step_o.status.active = 1'b1;
        step_o.status.mode   = exec_ready_i ? ModeNavigating : ModeWaiting;
        step_o.cmd           = exec_ready_i ? CmdDispatch : CmdWait;
      end
      OpReady: begin
        if (status_i.mode == ModeWaiting && status_i.active) begin
          step_o.status.mode = ModeNavigating;
          step_o.cmd         = CmdDispatch;
        end
      end
      OpSuccess: begin
        if (status_i.loaded && status_i.active) begin
          s.done  = sat_inc(status_i.done);
          s.retry = '0;
          step_o  = advance(s, more_points, cfg_i.wrap_route);
        end
      end
      OpError: begin
        if (status_i.loaded) begin
          if (index_out) begin
            step_o.status.mode   = ModeFailed;
            step_o.status.active = 1'b0;
            step_o.cmd           = CmdFail;
          end else if (status_i.retry < limit) begin
            step_o.status.retry = status_i.retry + RetryW'(1);
            step_o.status.mode  = ModeRetryWait;
            step_o.cmd          = CmdRetry;
          end else begin
            // Retries exhausted: the waypoint is given up.
            s.missed = sat_inc(status_i.missed);
            s.retry  = '0;
            if (cfg_i.skip_exhausted) begin
              step_o = advance(s, more_points, cfg_i.wrap_route);
            end else begin
              s.mode   = ModeFailed;
              s.active = 1'b0;
              step_o   = '{cmd: CmdFail, status: s};
            end
          end
        end
      end
      OpRetryTmr: begin
        if (status_i.mode == ModeRetryWait && status_i.active) begin
          step_o.status.mode = ModeNavigating;
          step_o.cmd         = CmdDispatch;
        end
      end
      OpStop: begin
        step_o.status.active = 1'b0;
        if (status_i.mode == ModeNavigating) begin
          step_o.status.mode = ModeStopping;
          step_o.cmd         = CmdCancel;
        end else begin
          step_o.status.mode = ModeIdle;
          step_o.cmd         = CmdStopped;
        end
      end
      OpStopDone: begin
        step_o.status.mode   = ModeIdle;
        step_o.status.active = 1'b0;
        step_o.cmd           = CmdStopped;
      end
      OpAbort: begin
        step_o.status.mode   = ModeFailed;
        step_o.status.active = 1'b0;
        step_o.cmd           = CmdFail;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: src/wms_checker.sv
// Port-level assertions for the waypoint mission sequencer and their binding.
`default_nettype none

module wms_checker import wms_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [CmdW-1:0]     command_o,
  input wire logic [ModeW-1:0]    mode_o,
  input wire logic                is_active_o,
  input wire logic [RetryW-1:0]   retry_number_o,
  input wire logic [CounterW-1:0] done_points_o
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(command_o) &&
      $stable(mode_o) && $stable(done_points_o))
    else $error("stalled result changed or vanished");

  // A dispatch always leaves the mission navigating. A skip after a goal error
  // may dispatch while the mission is inactive, so the active flag is not checked.
  a_dispatch_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_o == CmdDispatch |-> mode_o == ModeNavigating)
    else $error("dispatch without navigating mode");

  // A scheduled retry has used at least one retry and waits for its timer.
  a_retry_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_o == CmdRetry |-> mode_o == ModeRetryWait &&
      retry_number_o != '0)
    else $error("retry scheduled with inconsistent status");

  // Terminal and stopped modes never report an active mission.
  a_inactive_modes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o == ModeCompleted || mode_o == ModeFailed ||
      mode_o == ModeStopping || mode_o == ModeIdle) |-> !is_active_o)
    else $error("mission active in a terminal mode");

endmodule

bind waypoint_mission_sequencer wms_checker u_wms_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .command_o      (command_o),
  .mode_o         (mode_o),
  .is_active_o    (is_active_o),
  .retry_number_o (retry_number_o),
  .done_points_o  (done_points_o)
);

`default_nettype wire
